FILE: rtl/owvm_pkg.sv
// Package for the omni wheel velocity mixer: field widths, register indices
// and the heading cosine/sine table, which is built at elaboration time.
// No dependencies.
package owvm_pkg;

    // Fixed sizes
    localparam int WHEELS              = 4;
    localparam int MAX_DUTY            = 255;
    localparam int TRIG_FRAC_BITS_DEF  = 14;
    localparam int DEG_COUNT           = 360;
    localparam int HEAD_W              = 9;
    localparam int SPEED_W             = 11;
    localparam int SPIN_W              = 10;
    localparam int COEF_W              = 16;
    localparam int DUTY_W              = 8;
    localparam int WHEEL_OUT_W         = DUTY_W + 1;
    localparam int IN_FIELDS_W         = HEAD_W + SPEED_W + SPIN_W;
    localparam int IN_TDATA_W          = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W        = WHEELS * WHEEL_OUT_W;
    localparam int OUT_TDATA_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W         = 4;

    // Configuration register indices
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL0_COS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL0_SIN = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL1_COS = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL1_SIN = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL2_COS = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL2_SIN = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL3_COS = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL3_SIN = 4'd7;

    // Table generation: degrees to radians by 71/4068, Taylor series with
    // 50 fraction bits, then rounding half away from zero.
    localparam int SERIES_BITS = 50;
    localparam int RAD_NUM     = 71;
    localparam int RAD_DEN     = 4068;
    localparam int MAX_TERMS   = 64;

    typedef logic signed [31:0] trig_rom_t [DEG_COUNT];

    // (a*b) >> 50 over the full product
    function automatic logic [63:0] series_mul(input logic [63:0] a,
                                               input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[SERIES_BITS+63:SERIES_BITS];
    endfunction

    // Term divided by its index; each arm divides by a fixed number
    function automatic logic [63:0] series_div(input logic [63:0] t,
                                               input logic [6:0] n);
        logic [63:0] q;
        case (n)
            7'd2:  q = t / 2;   7'd3:  q = t / 3;   7'd4:  q = t / 4;
            7'd5:  q = t / 5;   7'd6:  q = t / 6;   7'd7:  q = t / 7;
            7'd8:  q = t / 8;   7'd9:  q = t / 9;   7'd10: q = t / 10;
            7'd11: q = t / 11;  7'd12: q = t / 12;  7'd13: q = t / 13;
            7'd14: q = t / 14;  7'd15: q = t / 15;  7'd16: q = t / 16;
            7'd17: q = t / 17;  7'd18: q = t / 18;  7'd19: q = t / 19;
            7'd20: q = t / 20;  7'd21: q = t / 21;  7'd22: q = t / 22;
            7'd23: q = t / 23;  7'd24: q = t / 24;  7'd25: q = t / 25;
            7'd26: q = t / 26;  7'd27: q = t / 27;  7'd28: q = t / 28;
            7'd29: q = t / 29;  7'd30: q = t / 30;  7'd31: q = t / 31;
            7'd32: q = t / 32;  7'd33: q = t / 33;  7'd34: q = t / 34;
            7'd35: q = t / 35;  7'd36: q = t / 36;  7'd37: q = t / 37;
            7'd38: q = t / 38;  7'd39: q = t / 39;  7'd40: q = t / 40;
            7'd41: q = t / 41;  7'd42: q = t / 42;  7'd43: q = t / 43;
            7'd44: q = t / 44;  7'd45: q = t / 45;  7'd46: q = t / 46;
            7'd47: q = t / 47;  7'd48: q = t / 48;  7'd49: q = t / 49;
            7'd50: q = t / 50;  7'd51: q = t / 51;  7'd52: q = t / 52;
            7'd53: q = t / 53;  7'd54: q = t / 54;  7'd55: q = t / 55;
            7'd56: q = t / 56;  7'd57: q = t / 57;  7'd58: q = t / 58;
            7'd59: q = t / 59;  7'd60: q = t / 60;  7'd61: q = t / 61;
            7'd62: q = t / 62;  7'd63: q = t / 63;  7'd64: q = t / 64;
            default: q = t;
        endcase
        return q;
    endfunction

    // Round a 50-fraction-bit value to frac bits, ties away from zero
    function automatic logic signed [31:0] round_trig(input logic signed [63:0] v,
                                                      input int unsigned frac);
        logic [63:0] mag;
        int unsigned sh;
        sh  = SERIES_BITS - frac;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    // Whole table, cosine or sine, one entry per degree
    function automatic trig_rom_t build_trig(input bit want_sin,
                                             input int unsigned frac);
        trig_rom_t rom;
        logic [63:0] num, q, r, x, t;
        logic signed [63:0] c, s;
        bit stop;
        for (int d = 0; d < DEG_COUNT; d++) begin
            num  = 64'(d) * 64'(RAD_NUM);
            q    = num / RAD_DEN;
            r    = num % RAD_DEN;
            x    = (q << SERIES_BITS) + ((r << SERIES_BITS) / RAD_DEN);
            t    = 64'd1 << SERIES_BITS;
            c    = $signed(t);
            s    = 64'sd0;
            stop = 1'b0;
            for (int n = 1; n <= MAX_TERMS; n++) begin
                if (!stop) begin
                    t = series_div(series_mul(t, x), 7'(n));
                    if (t == 64'd0) begin
                        stop = 1'b1;
                    end else begin
                        case (n % 4)
                            0:       c = c + $signed(t);
                            1:       s = s + $signed(t);
                            2:       c = c - $signed(t);
                            default: s = s - $signed(t);
                        endcase
                    end
                end
            end
            rom[d] = round_trig(want_sin ? s : c, frac);
        end
        return rom;
    endfunction

endpackage

FILE: rtl/omni_wheel_velocity_mixer.sv
// Omni wheel velocity mixer: heading/speed/spin command in, four wheel
// direction and duty pairs out. Uses owvm_pkg (widths, indices, trig table).
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | heading_deg, speed, spin (one command)
//  m_*      | out       | forward and duty for wheels 0..3 (one result)
//  cfg_*    | in        | wheel cosine/sine coefficient writes, index 0..7
//
// Eight register stages; a command passes through each of them in turn before
// it is on m_. One command enters per cycle while s_tready is high.
// Each stage advances when it is empty or the stage after it advances, so a
// held output fills the pipe up before s_tready drops; nothing is dropped.
// aresetn clears the valid bits and the coefficient registers (all zero).
// cfg_ready is always high; writes to indices above 7 are ignored.
module omni_wheel_velocity_mixer
    import owvm_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: heading_deg [8:0], speed [19:9], spin [29:20], zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: per wheel w at 9*w: forward (1 bit), duty (8 bits); zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam int NS  = 8;                    // register stages
    localparam int TW  = TRIG_FRAC_BITS + 2;   // table word
    localparam int PW  = COEF_W + TW;          // coefficient x trig
    localparam int DW  = PW + 1;               // difference of products
    localparam int MW  = DW + SPEED_W;         // times speed
    localparam int AW  = MW + 1;               // plus spin
    localparam int SH  = 2 * TRIG_FRAC_BITS;   // scale shift
    localparam int VW  = AW - SH;              // integer part

    localparam trig_rom_t TRIG_COS = build_trig(1'b0, TRIG_FRAC_BITS);
    localparam trig_rom_t TRIG_SIN = build_trig(1'b1, TRIG_FRAC_BITS);

    // Configuration registers
    logic signed [COEF_W-1:0] wcos_reg [WHEELS];
    logic signed [COEF_W-1:0] wsin_reg [WHEELS];
    logic signed [COEF_W-1:0] wcos_next [WHEELS];
    logic signed [COEF_W-1:0] wsin_next [WHEELS];

    // Pipeline control
    logic [NS-1:0] vld_reg, vld_next, en;

    // Stage registers
    logic [HEAD_W-1:0]         head_reg, head_next;
    logic signed [SPEED_W-1:0] spd1_reg, spd2_reg, spd3_reg, spd4_reg;
    logic signed [SPIN_W-1:0]  spn1_reg, spn2_reg, spn3_reg, spn4_reg, spn5_reg;
    logic signed [TW-1:0]      hcos_reg, hsin_reg, hcos_next, hsin_next;
    logic signed [PW-1:0]      pa_reg [WHEELS];
    logic signed [PW-1:0]      pb_reg [WHEELS];
    logic signed [PW-1:0]      pa_next [WHEELS];
    logic signed [PW-1:0]      pb_next [WHEELS];
    logic signed [DW-1:0]      df_reg [WHEELS];
    logic signed [DW-1:0]      df_next [WHEELS];
    logic signed [MW-1:0]      mx_reg [WHEELS];
    logic signed [MW-1:0]      mx_next [WHEELS];
    logic signed [AW-1:0]      ac_reg [WHEELS];
    logic signed [AW-1:0]      ac_next [WHEELS];
    logic signed [VW-1:0]      vt_reg [WHEELS];
    logic signed [VW-1:0]      vt_next [WHEELS];
    logic [OUT_FIELDS_W-1:0]   out_reg, out_next;

    logic [HEAD_W-1:0] in_head;

    assign in_head   = s_tdata[HEAD_W-1:0];
    assign cfg_ready = 1'b1;

    // Coefficient write decode
    always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
            wcos_next[w] = wcos_reg[w];
            wsin_next[w] = wsin_reg[w];
        end
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WHEEL0_COS: wcos_next[0] = cfg_data;
                REG_WHEEL0_SIN: wsin_next[0] = cfg_data;
                REG_WHEEL1_COS: wcos_next[1] = cfg_data;
                REG_WHEEL1_SIN: wsin_next[1] = cfg_data;
                REG_WHEEL2_COS: wcos_next[2] = cfg_data;
                REG_WHEEL2_SIN: wsin_next[2] = cfg_data;
                REG_WHEEL3_COS: wcos_next[3] = cfg_data;
                REG_WHEEL3_SIN: wsin_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables, from the output back to the input
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NS; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready = en[0];

    // Datapath next values
    always_comb begin
        // heading wrap
        head_next = (in_head >= HEAD_W'(DEG_COUNT)) ? in_head - HEAD_W'(DEG_COUNT)
                                                    : in_head;
        // table lookup
        hcos_next = TRIG_COS[head_reg][TW-1:0];
        hsin_next = TRIG_SIN[head_reg][TW-1:0];
        for (int w = 0; w < WHEELS; w++) begin
            // wheel coefficient times heading trig
            pa_next[w] = {{TW{wcos_reg[w][COEF_W-1]}}, wcos_reg[w]}
                       * {{COEF_W{hsin_reg[TW-1]}}, hsin_reg};
            pb_next[w] = {{TW{wsin_reg[w][COEF_W-1]}}, wsin_reg[w]}
                       * {{COEF_W{hcos_reg[TW-1]}}, hcos_reg};
            df_next[w] = {pa_reg[w][PW-1], pa_reg[w]} - {pb_reg[w][PW-1], pb_reg[w]};
            // times speed
            mx_next[w] = {{SPEED_W{df_reg[w][DW-1]}}, df_reg[w]}
                       * {{DW{spd4_reg[SPEED_W-1]}}, spd4_reg};
            // plus spin at full scale
            ac_next[w] = {mx_reg[w][MW-1], mx_reg[w]}
                       + ({{(AW-SPIN_W){spn5_reg[SPIN_W-1]}}, spn5_reg} << SH);
            // truncate toward zero
            vt_next[w] = ac_reg[w][AW-1:SH]
                       + VW'(ac_reg[w][AW-1] && (|ac_reg[w][SH-1:0]));
        end
    end

    // Direction and saturated duty
    always_comb begin
        logic [VW-1:0] mag;
        out_next = '0;
        for (int w = 0; w < WHEELS; w++) begin
            mag = vt_reg[w][VW-1] ? VW'(-vt_reg[w]) : VW'(vt_reg[w]);
            out_next[w*WHEEL_OUT_W] = !vt_reg[w][VW-1];
            out_next[w*WHEEL_OUT_W+1 +: DUTY_W] =
                (mag > VW'(MAX_DUTY)) ? DUTY_W'(MAX_DUTY) : mag[DUTY_W-1:0];
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int w = 0; w < WHEELS; w++) begin
                wcos_reg[w] <= '0;
                wsin_reg[w] <= '0;
            end
        end else begin
            vld_reg <= vld_next;
            for (int w = 0; w < WHEELS; w++) begin
                wcos_reg[w] <= wcos_next[w];
                wsin_reg[w] <= wsin_next[w];
            end
        end
    end

    // Payload registers, each loaded when its stage advances
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            head_reg <= head_next;
            spd1_reg <= s_tdata[HEAD_W +: SPEED_W];
            spn1_reg <= s_tdata[HEAD_W+SPEED_W +: SPIN_W];
        end
        if (en[1]) begin
            hcos_reg <= hcos_next;
            hsin_reg <= hsin_next;
            spd2_reg <= spd1_reg;
            spn2_reg <= spn1_reg;
        end
        if (en[2]) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            spd3_reg <= spd2_reg;
            spn3_reg <= spn2_reg;
        end
        if (en[3]) begin
            df_reg   <= df_next;
            spd4_reg <= spd3_reg;
            spn4_reg <= spn3_reg;
        end
        if (en[4]) begin
            mx_reg   <= mx_next;
            spn5_reg <= spn4_reg;
        end
        if (en[5]) begin
            ac_reg <= ac_next;
        end
        if (en[6]) begin
            vt_reg <= vt_next;
        end
        if (en[7]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_reg};

endmodule

FILE: rtl/owvm_checker.sv
// Port-level checks for the omni wheel velocity mixer, bound to the top
// level. Uses owvm_pkg for the port widths.
module owvm_checker
    import owvm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Nothing is offered on the output straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held output transaction changed");

    // A draining output never stalls the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while output drains");

    // With the output draining throughout, an accepted command comes out on m_
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind omni_wheel_velocity_mixer owvm_checker u_owvm_checker (.*);
